// File: hw/rtl/event_transition_ngram_counter_macros.svh
// assertion helpers used by etnc_engine.sv
`ifndef EVENT_TRANSITION_NGRAM_COUNTER_MACROS_SVH
`define EVENT_TRANSITION_NGRAM_COUNTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ETNC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ETNC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/etnc_pkg.sv
package etnc_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int NUM_TABLES  = 4;
    localparam int TBL_W       = 2;
    localparam int ID_W        = 16;
    localparam int KEY_W       = 3 * ID_W;
    localparam int COUNT_W     = 32;
    // valid bit, key, count
    localparam int MEM_W       = 1 + KEY_W + COUNT_W;
    localparam int MEM_DEPTH   = NUM_TABLES * TABLE_SLOTS;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int OUT_W       = 248;

    localparam logic OP_INGEST = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [1:0] REG_ORDER     = 2'd0;
    localparam logic [1:0] REG_TRANS_CAP = 2'd1;
    localparam logic [1:0] REG_NGRAM_CAP = 2'd2;

    localparam logic [1:0] ORDER_TRIGRAM = 2'd3;

    typedef enum logic [TBL_W-1:0] {
        TBL_EVENT   = 2'd0,
        TBL_TRANS   = 2'd1,
        TBL_BIGRAM  = 2'd2,
        TBL_TRIGRAM = 2'd3
    } tbl_t;

    typedef struct packed {
        logic             start;
        logic             clear;
        tbl_t             tbl;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cap;
    } lookup_req_t;

    typedef struct packed {
        logic               idle;
        logic               done;
        logic               dropped;
        logic [COUNT_W-1:0] count;
    } lookup_rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0] distinct_ids;
        logic [CNT_W-1:0] edges;
    } table_used_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_hash(input logic [KEY_W-1:0] key);
        logic [SLOT_W-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % SLOT_W] = h[i % SLOT_W] ^ key[i];
        end
        return h;
    endfunction

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
        return (cap > CNT_W'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS) : cap;
    endfunction

endpackage

// File: hw/rtl/event_transition_ngram_counter.sv
// Counts a stream of 16-bit event ids in four hashed tables that share one
// 1024 x 81 single-port memory (valid bit, key, count): per-event counts,
// previous-to-current transitions, bigrams and (at order 3) trigrams. One shared
// probe unit visits the tables one after another; a lookup starts, then for
// every slot it visits it reads the slot, then compares and writes back. A clear
// beat runs a pass that rewrites all 1024 words before it gives its result; the
// same pass runs after reset, so no input beat is taken until it ends. Input and
// result sides are split by the result register, so a new beat is taken while
// the last result waits.
module event_transition_ngram_counter (
    input  logic         clk,
    input  logic         rst_n,
    // config
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // id
    input  logic [0:0]   s_tuser,   // op
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_count, transition_count, bigram_count, trigram_count, drop_flags,
    // total_ingested, distinct_ids, edge_total, bigram_total, trigram_total
    output logic [247:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } top_state_t;

    localparam int KW = etnc_pkg::KEY_W;
    localparam int IW = etnc_pkg::ID_W;
    localparam int CW = etnc_pkg::COUNT_W;

    top_state_t                          state_reg, state_next;
    logic [1:0]                          order_reg, order_next;
    logic [etnc_pkg::CNT_W-1:0]          tcap_reg, tcap_next;
    logic [etnc_pkg::CNT_W-1:0]          ncap_reg, ncap_next;
    logic [IW-1:0]                       prev1_reg, prev1_next;
    logic [IW-1:0]                       prev2_reg, prev2_next;
    logic [1:0]                          fill_reg, fill_next;
    logic [IW-1:0]                       id_reg, id_next;
    logic [2*IW-1:0]                     pair_key_reg, pair_key_next;
    logic [KW-1:0]                       tri_key_reg, tri_key_next;
    logic [etnc_pkg::NUM_TABLES-1:0]     jobs_reg, jobs_next;
    etnc_pkg::tbl_t                      cur_reg, cur_next;
    logic [etnc_pkg::NUM_TABLES-1:0][CW-1:0] cnt_reg, cnt_next;
    logic [etnc_pkg::NUM_TABLES-1:0]     flags_reg, flags_next;
    logic [CW-1:0]                       ing_reg, ing_next;
    logic [CW-1:0]                       bgt_reg, bgt_next;
    logic [CW-1:0]                       tgt_reg, tgt_next;
    logic                                m_valid_reg, m_valid_next;
    logic [etnc_pkg::OUT_W-1:0]          m_data_reg, m_data_next;

    etnc_pkg::lookup_req_t               req;
    etnc_pkg::lookup_rsp_t               rsp;
    etnc_pkg::table_used_t               used;
    etnc_pkg::tbl_t                      pick;
    logic                                s_acc;
    logic                                cfg_wr;
    logic [IW-1:0]                       in_id;

    etnc_engine u_engine (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .used (used)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == ST_IDLE) && rsp.idle;
    assign s_acc    = s_tvalid && s_tready;
    assign in_id    = s_tdata;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            etnc_pkg::REG_ORDER:     prdata = {30'd0, order_reg};
            etnc_pkg::REG_TRANS_CAP: prdata = {23'd0, tcap_reg};
            etnc_pkg::REG_NGRAM_CAP: prdata = {23'd0, ncap_reg};
            default:                 prdata = '0;
        endcase
    end

    // lowest pending table goes next
    always_comb
    begin
        priority if (jobs_reg[etnc_pkg::TBL_EVENT])  pick = etnc_pkg::TBL_EVENT;
        else if (jobs_reg[etnc_pkg::TBL_TRANS])      pick = etnc_pkg::TBL_TRANS;
        else if (jobs_reg[etnc_pkg::TBL_BIGRAM])     pick = etnc_pkg::TBL_BIGRAM;
        else                                         pick = etnc_pkg::TBL_TRIGRAM;
    end

    always_comb
    begin
        state_next    = state_reg;
        order_next    = order_reg;
        tcap_next     = tcap_reg;
        ncap_next     = ncap_reg;
        prev1_next    = prev1_reg;
        prev2_next    = prev2_reg;
        fill_next     = fill_reg;
        id_next       = id_reg;
        pair_key_next = pair_key_reg;
        tri_key_next  = tri_key_reg;
        jobs_next     = jobs_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        flags_next    = flags_reg;
        ing_next      = ing_reg;
        bgt_next      = bgt_reg;
        tgt_next      = tgt_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        req           = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                etnc_pkg::REG_ORDER:     order_next = pwdata[1:0];
                etnc_pkg::REG_TRANS_CAP: tcap_next  = pwdata[etnc_pkg::CNT_W-1:0];
                etnc_pkg::REG_NGRAM_CAP: ncap_next  = pwdata[etnc_pkg::CNT_W-1:0];
                default:                 ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    cnt_next   = '0;
                    flags_next = '0;
                    if (s_tuser[0] == etnc_pkg::OP_CLEAR)
                    begin
                        // wait for the wipe pass, then report an all-zero beat
                        req.clear  = 1'b1;
                        prev1_next = '0;
                        prev2_next = '0;
                        fill_next  = '0;
                        ing_next   = '0;
                        bgt_next   = '0;
                        tgt_next   = '0;
                        jobs_next  = '0;
                        cur_next   = etnc_pkg::TBL_EVENT;
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        id_next       = in_id;
                        pair_key_next = {prev1_reg, in_id};
                        tri_key_next  = {prev2_reg, prev1_reg, in_id};
                        jobs_next[etnc_pkg::TBL_EVENT]   = 1'b1;
                        jobs_next[etnc_pkg::TBL_TRANS]   = (fill_reg != 2'd0);
                        jobs_next[etnc_pkg::TBL_BIGRAM]  = (fill_reg != 2'd0);
                        jobs_next[etnc_pkg::TBL_TRIGRAM] =
                            (order_reg == etnc_pkg::ORDER_TRIGRAM) && (fill_reg >= 2'd2);
                        prev2_next = prev1_reg;
                        prev1_next = in_id;
                        fill_next  = (fill_reg == 2'd3) ? 2'd3 : fill_reg + 2'd1;
                        ing_next   = etnc_pkg::sat_inc(ing_reg);
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                if (jobs_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    req.start       = 1'b1;
                    req.tbl         = pick;
                    cur_next        = pick;
                    jobs_next[pick] = 1'b0;
                    unique case (pick)
                        etnc_pkg::TBL_EVENT:
                        begin
                            req.key = {{(KW-IW){1'b0}}, id_reg};
                            req.cap = etnc_pkg::CNT_W'(etnc_pkg::TABLE_SLOTS);
                        end
                        etnc_pkg::TBL_TRANS:
                        begin
                            req.key = {{(KW-2*IW){1'b0}}, pair_key_reg};
                            req.cap = etnc_pkg::eff_cap(tcap_reg);
                        end
                        etnc_pkg::TBL_BIGRAM:
                        begin
                            req.key = {{(KW-2*IW){1'b0}}, pair_key_reg};
                            req.cap = etnc_pkg::eff_cap(ncap_reg);
                        end
                        default:
                        begin
                            req.key = tri_key_reg;
                            req.cap = etnc_pkg::eff_cap(ncap_reg);
                        end
                    endcase
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    cnt_next[cur_reg]   = rsp.count;
                    flags_next[cur_reg] = rsp.dropped;
                    if (!rsp.dropped && (cur_reg == etnc_pkg::TBL_BIGRAM))
                    begin
                        bgt_next = etnc_pkg::sat_inc(bgt_reg);
                    end
                    if (!rsp.dropped && (cur_reg == etnc_pkg::TBL_TRIGRAM))
                    begin
                        tgt_next = etnc_pkg::sat_inc(tgt_reg);
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, tgt_reg, bgt_reg, used.edges,
                                    used.distinct_ids, ing_reg, flags_reg,
                                    cnt_reg[etnc_pkg::TBL_TRIGRAM],
                                    cnt_reg[etnc_pkg::TBL_BIGRAM],
                                    cnt_reg[etnc_pkg::TBL_TRANS],
                                    cnt_reg[etnc_pkg::TBL_EVENT]};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            order_reg   <= 2'd3;
            tcap_reg    <= etnc_pkg::CNT_W'(256);
            ncap_reg    <= etnc_pkg::CNT_W'(256);
            prev1_reg   <= '0;
            prev2_reg   <= '0;
            fill_reg    <= '0;
            jobs_reg    <= '0;
            ing_reg     <= '0;
            bgt_reg     <= '0;
            tgt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            order_reg   <= order_next;
            tcap_reg    <= tcap_next;
            ncap_reg    <= ncap_next;
            prev1_reg   <= prev1_next;
            prev2_reg   <= prev2_next;
            fill_reg    <= fill_next;
            jobs_reg    <= jobs_next;
            ing_reg     <= ing_next;
            bgt_reg     <= bgt_next;
            tgt_reg     <= tgt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        pair_key_reg <= pair_key_next;
        tri_key_reg  <= tri_key_next;
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        flags_reg    <= flags_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// File: hw/rtl/etnc_ram.sv
module etnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: hw/rtl/etnc_engine.sv
`include "event_transition_ngram_counter_macros.svh"

module etnc_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  etnc_pkg::lookup_req_t req,
    output etnc_pkg::lookup_rsp_t rsp,
    output etnc_pkg::table_used_t used
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_WIPE  = 4'b1000
    } eng_state_t;

    eng_state_t                                   state_reg, state_next;
    etnc_pkg::tbl_t                               tbl_reg, tbl_next;
    logic [etnc_pkg::KEY_W-1:0]                   key_reg, key_next;
    logic [etnc_pkg::CNT_W-1:0]                   cap_reg, cap_next;
    logic [etnc_pkg::SLOT_W-1:0]                  slot_reg, slot_next;
    logic [etnc_pkg::CNT_W-1:0]                   probe_reg, probe_next;
    logic [etnc_pkg::ADDR_W-1:0]                  wipe_reg, wipe_next;
    logic [etnc_pkg::NUM_TABLES-1:0][etnc_pkg::CNT_W-1:0] used_reg, used_next;

    logic                                         ram_en;
    logic                                         ram_we;
    logic [etnc_pkg::ADDR_W-1:0]                  ram_addr;
    logic [etnc_pkg::MEM_W-1:0]                   ram_wdata;
    logic [etnc_pkg::MEM_W-1:0]                   ram_rdata;

    logic                                         rd_valid;
    logic [etnc_pkg::KEY_W-1:0]                   rd_key;
    logic                                         hit;
    logic [etnc_pkg::COUNT_W-1:0]                 hit_count;

    etnc_ram #(
        .WIDTH(etnc_pkg::MEM_W),
        .DEPTH(etnc_pkg::MEM_DEPTH)
    ) u_ram (
        .clk  (clk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign rd_valid  = ram_rdata[etnc_pkg::MEM_W-1];
    assign rd_key    = ram_rdata[etnc_pkg::MEM_W-2:etnc_pkg::COUNT_W];
    assign hit       = rd_valid && (rd_key == key_reg);
    assign hit_count = etnc_pkg::sat_inc(ram_rdata[etnc_pkg::COUNT_W-1:0]);

    assign used.distinct_ids = used_reg[etnc_pkg::TBL_EVENT];
    assign used.edges        = used_reg[etnc_pkg::TBL_TRANS];

    always_comb
    begin
        state_next = state_reg;
        tbl_next   = tbl_reg;
        key_next   = key_reg;
        cap_next   = cap_reg;
        slot_next  = slot_reg;
        probe_next = probe_reg;
        wipe_next  = wipe_reg;
        used_next  = used_reg;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = {tbl_reg, slot_reg};
        ram_wdata  = {1'b1, key_reg, etnc_pkg::COUNT_W'(1)};
        rsp        = '0;
        rsp.idle   = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.clear)
                begin
                    used_next  = '0;
                    wipe_next  = '0;
                    state_next = ST_WIPE;
                end
                else if (req.start)
                begin
                    tbl_next   = req.tbl;
                    key_next   = req.key;
                    cap_next   = req.cap;
                    slot_next  = etnc_pkg::slot_hash(req.key);
                    probe_next = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // every slot visited without a match or a free slot
                if (probe_reg == etnc_pkg::CNT_W'(etnc_pkg::TABLE_SLOTS))
                begin
                    rsp.done    = 1'b1;
                    rsp.dropped = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ram_en     = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (hit)
                begin
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_wdata  = {1'b1, key_reg, hit_count};
                    rsp.done   = 1'b1;
                    rsp.count  = hit_count;
                    state_next = ST_IDLE;
                end
                else if (!rd_valid)
                begin
                    // new key: stored only below the cap
                    if (used_reg[tbl_reg] >= cap_reg)
                    begin
                        rsp.done    = 1'b1;
                        rsp.dropped = 1'b1;
                    end
                    else
                    begin
                        ram_en             = 1'b1;
                        ram_we             = 1'b1;
                        used_next[tbl_reg] = etnc_pkg::CNT_W'(used_reg[tbl_reg] + 1'b1);
                        rsp.done           = 1'b1;
                        rsp.count          = etnc_pkg::COUNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    probe_next = etnc_pkg::CNT_W'(probe_reg + 1'b1);
                    state_next = ST_PROBE;
                end
            end
            ST_WIPE:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = wipe_reg;
                ram_wdata = '0;
                wipe_next = wipe_reg + 1'b1;
                if (wipe_reg == {etnc_pkg::ADDR_W{1'b1}})
                begin
                    rsp.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory contents are unknown after reset, so reset starts a wipe pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE;
            wipe_reg  <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wipe_reg  <= wipe_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg   <= tbl_next;
        key_reg   <= key_next;
        cap_reg   <= cap_next;
        slot_reg  <= slot_next;
        probe_reg <= probe_next;
    end

    `ETNC_ASSERT_IMP(a_start_when_idle, req.start, state_reg == ST_IDLE,
        "lookup started while busy")
    `ETNC_ASSERT_IMP(a_drop_no_write, rsp.done && rsp.dropped, (rsp.count == '0) && !ram_we,
        "dropped key wrote memory or returned a count")
    `ETNC_ASSERT_IMP(a_hit_writes_back, (state_reg == ST_CMP) && ram_we,
        ram_addr == $past(ram_addr), "write-back went to a different slot than the read")
    `ETNC_ASSERT_NXT(a_read_then_cmp, (state_reg == ST_PROBE) && ram_en, state_reg == ST_CMP,
        "probe read not followed by compare")

endmodule
